/* rtl/sclr_pkg.sv */
// Shared types, constants and register codes of the serial command link.
package sclr_pkg;

	// default sizes
	localparam int DEF_QUEUE_DEPTH  = 8;
	localparam int DEF_REPLY_LENGTH = 5;

	// field and counter widths
	localparam int TICK_W     = 16;
	localparam int CNT_W      = TICK_W + 1;
	localparam int TRY_W      = 4;
	localparam int BYTE_W     = 8;
	localparam int TXP_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// frame and reply bytes
	localparam logic [BYTE_W-1:0] HDR_BYTE      = 8'h02;
	localparam logic [BYTE_W-1:0] REPLY_HDR     = 8'h82;
	localparam logic [BYTE_W-1:0] STATUS_ID     = 8'hC6;
	localparam logic [BYTE_W-1:0] POWER_ODD     = 8'hE0;
	localparam logic [BYTE_W-1:0] LEN_WITH_DATA = 8'h01;
	localparam int                POWER_BIT     = 7;

	// frame lengths and byte positions within a frame
	localparam logic [TXP_W-1:0] FRAME_LEN_DATA = 3'd5;
	localparam logic [TXP_W-1:0] FRAME_LEN_BARE = 3'd4;
	localparam logic [TXP_W-1:0] TXP_HDR        = 3'd0;
	localparam logic [TXP_W-1:0] TXP_CODE       = 3'd1;
	localparam logic [TXP_W-1:0] TXP_LEN        = 3'd2;
	localparam logic [TXP_W-1:0] TXP_DATA       = 3'd3;

	// register reset values
	localparam logic [TICK_W-1:0] RST_SEND_DELAY    = 16'd350;
	localparam logic [TICK_W-1:0] RST_POLL_INTERVAL = 16'd1100;
	localparam logic [TICK_W-1:0] RST_READY_DELAY   = 16'd3000;
	localparam logic [TICK_W-1:0] RST_REPLY_TIMEOUT = 16'd500;
	localparam logic [TICK_W-1:0] RST_OFFLINE       = 16'd10000;
	localparam logic [TRY_W-1:0]  RST_MAX_TRIES     = 4'd3;
	localparam logic [BYTE_W-1:0] RST_STATUS_CODE   = 8'd0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEND_DELAY    = 3'd0,
		REG_POLL_INTERVAL = 3'd1,
		REG_READY_DELAY   = 3'd2,
		REG_REPLY_TIMEOUT = 3'd3,
		REG_OFFLINE       = 3'd4,
		REG_MAX_TRIES     = 3'd5,
		REG_STATUS_CODE   = 3'd6
	} cfg_reg_t;

	// item kinds
	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_ENQUEUE = 2'd1,
		MODE_TX_REQ  = 2'd2,
		MODE_RX_BYTE = 2'd3
	} mode_t;

	// one queued command
	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic [BYTE_W-1:0] data;
		logic              has_data;
	} slot_t;

	// input beat
	typedef struct packed {
		mode_t             mode;
		logic [BYTE_W-1:0] cmd_code;
		logic [BYTE_W-1:0] cmd_data;
		logic              has_data;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              tx_valid;
		logic              frame_sent;
		logic              start_send;
		logic              reply_received;
		logic              power_on;
		logic              power_ready;
		logic              offline;
	} result_t;

endpackage

/* rtl/sclr_queue.sv */
// Command ring storage with per-slot valid bits and a prefetched head slot.
module sclr_queue import sclr_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             wr_en,
	input  logic [PTR_W-1:0] wr_addr,
	input  slot_t            wr_slot,
	input  logic [PTR_W-1:0] rd_addr,
	output slot_t            head
);

	slot_t            mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DEPTH-1:0] wr_mask;
	slot_t            rd_q;
	logic             rd_valid_q;
	logic             hit_q;
	slot_t            hit_slot_q;

	// one-hot mark of the slot written this cycle
	assign wr_mask = wr_en ? (DEPTH'(1) << wr_addr) : '0;

	// write the slot array, read the next head slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_slot;
		end
		rd_q <= mem[rd_addr];
	end

	// track written slots, drop all on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			hit_q      <= 1'b0;
			hit_slot_q <= '0;
		end else begin
			valid_q    <= (clear ? '0 : valid_q) | wr_mask;
			rd_valid_q <= !clear && valid_q[rd_addr];
			hit_q      <= wr_en && (wr_addr == rd_addr);
			hit_slot_q <= wr_slot;
		end
	end

	// forward a same-cycle write, unwritten slots read as zero
	assign head = hit_q ? hit_slot_q : (rd_valid_q ? rd_q : '0);

endmodule

/* rtl/sclr_skid.sv */
// Two-entry result buffer between the control logic and the output channel.
module sclr_skid import sclr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    space,
	output logic    dout_valid,
	input  logic    dout_ready,
	output result_t dout
);

	result_t head_q;
	result_t spare_q;
	logic    head_valid_q;
	logic    spare_valid_q;

	assign space      = !spare_valid_q;
	assign dout_valid = head_valid_q;
	assign dout       = head_q;

	// advance the head when it is free or taken, park a beat otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
			head_q        <= '0;
			spare_q       <= '0;
		end else if (!head_valid_q || dout_ready) begin
			if (spare_valid_q) begin
				head_q        <= spare_q;
				head_valid_q  <= 1'b1;
				spare_valid_q <= 1'b0;
			end else begin
				head_q       <= din;
				head_valid_q <= push;
			end
		end else if (push) begin
			spare_q       <= din;
			spare_valid_q <= 1'b1;
		end
	end

endmodule

/* rtl/serial_command_link_with_retry.sv */
// Top level of the serial command link with retry and status polling.
//
// Input channel (in_valid/in_ready/in_data) carries one event per beat: a
// millisecond tick, a command to queue, a transmitter byte request or a
// received byte. Every accepted beat yields exactly one result beat on the
// output channel (out_valid/out_ready/out_data): the next frame byte, frame
// and reply strobes, and the current power and offline flags.
// Each event is handled combinationally; its result is registered in the
// result buffer, and one beat can be accepted every cycle while the buffer
// has space. The rate rests on the registered update of the queue pointers,
// tick counters and reply buffer, plus the registered read of the head command slot.
// A two-entry result buffer keeps the input open while one result waits; when
// the receiver stalls and both entries fill, in_ready drops until a beat is
// taken. Nothing is lost or repeated under stalls.
// Configuration writes (cfg_valid/cfg_index/cfg_data) are always ready; the user
// must issue them while the link is idle, as the block does not enforce it; indexes
// beyond the list are ignored. Reset (arst_n, asynchronous) loads the register
// defaults, queues one status poll with a send pending, and clears all flags and counters.
module serial_command_link_with_retry import sclr_pkg::*; #(
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
	parameter int REPLY_LENGTH = DEF_REPLY_LENGTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int RXW   = $clog2(REPLY_LENGTH);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W-1:0] FIRST_PTR = PTR_W'(1);
	localparam logic [RXW:0]     RLEN      = (RXW + 1)'(REPLY_LENGTH);

	// configuration registers
	logic [TICK_W-1:0] send_delay_q, poll_interval_q, ready_delay_q;
	logic [TICK_W-1:0] reply_timeout_q, offline_ticks_q;
	logic [TRY_W-1:0]  max_tries_q;
	logic [BYTE_W-1:0] status_code_q;

	// link state
	logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d, wp_enq, rp_next;
	logic [BYTE_W-1:0] last_code_q, last_code_d;
	logic              pend_q, pend_d, await_q, await_d, cmpl_q, cmpl_d;
	logic              pw_on_q, pw_on_d, pw_seen_q, pw_seen_d;
	logic              pw_ready_q, pw_ready_d, offline_q, offline_d;
	logic [CNT_W-1:0]  cnt_send_q, cnt_send_d, cnt_poll_q, cnt_poll_d;
	logic [CNT_W-1:0]  cnt_ready_q, cnt_ready_d, cnt_sil_q, cnt_sil_d;
	logic [TICK_W-1:0] cnt_reply_q, cnt_reply_d;
	logic [CNT_W-1:0]  cnt_reply_inc;
	logic [TRY_W-1:0]  try_q, try_d, try_inc;
	logic [TXP_W-1:0]  txpos_q, txpos_d, frame_len;
	logic [RXW-1:0]    rxpos_q, rxpos_d, rx_slot;
	logic [RXW:0]      rx_inc;
	logic [BYTE_W-1:0] rb_q [REPLY_LENGTH];
	logic [BYTE_W-1:0] rb_d [REPLY_LENGTH];
	logic [BYTE_W-1:0] first_byte, frame_sum;

	// queue access
	logic       q_clr, q_we;
	logic [PTR_W-1:0] q_waddr;
	slot_t      q_wslot, head, status_slot;

	logic       in_fire, space;
	result_t    res;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = space;
	assign cfg_ready = 1'b1;

	assign status_slot = '{code: status_code_q, data: '0, has_data: 1'b0};

	// ring stepping: enqueue never lands on the read slot
	assign rp_next = (rp_q == LAST_PTR) ? '0 : rp_q + FIRST_PTR;
	always_comb begin
		wp_enq = (wp_q == LAST_PTR) ? '0 : wp_q + FIRST_PTR;
		if (wp_enq == rp_q) begin
			wp_enq = wp_q;
		end
	end

	// frame bytes of the head command
	assign frame_len = head.has_data ? FRAME_LEN_DATA : FRAME_LEN_BARE;
	assign frame_sum = HDR_BYTE + head.code + {7'b0, head.has_data};

	// reply capture helpers
	assign rx_slot    = ({1'b0, rxpos_q} >= RLEN) ? '0 : rxpos_q;
	assign rx_inc     = {1'b0, rx_slot} + 1'b1;
	assign first_byte = (rx_slot == '0) ? in_data.rx_byte : rb_q[0];

	assign cnt_reply_inc = {1'b0, cnt_reply_q} + 1'b1;
	assign try_inc       = try_q + 1'b1;

	// next-state and result of one event
	always_comb begin
		wp_d        = wp_q;
		rp_d        = rp_q;
		last_code_d = last_code_q;
		pend_d      = pend_q;
		await_d     = await_q;
		cmpl_d      = cmpl_q;
		pw_on_d     = pw_on_q;
		pw_seen_d   = pw_seen_q;
		pw_ready_d  = pw_ready_q;
		offline_d   = offline_q;
		cnt_send_d  = cnt_send_q;
		cnt_poll_d  = cnt_poll_q;
		cnt_ready_d = cnt_ready_q;
		cnt_sil_d   = cnt_sil_q;
		cnt_reply_d = cnt_reply_q;
		try_d       = try_q;
		txpos_d     = txpos_q;
		rxpos_d     = rxpos_q;
		rb_d        = rb_q;
		q_clr       = 1'b0;
		q_we        = 1'b0;
		q_waddr     = wp_q;
		q_wslot     = status_slot;
		res         = '0;

		if (in_fire) begin
			case (in_data.mode)
				MODE_TICK: begin
					// send delay, or idle poll and ready delay
					if (pend_q) begin
						if (cnt_send_q > {1'b0, send_delay_q}) begin
							pend_d         = 1'b0;
							rxpos_d        = '0;
							cnt_send_d     = '0;
							res.start_send = 1'b1;
						end else begin
							cnt_send_d = cnt_send_q + 1'b1;
						end
						cnt_poll_d = '0;
					end else begin
						if (cnt_poll_q > {1'b0, poll_interval_q}) begin
							cnt_poll_d  = '0;
							q_we        = 1'b1;
							last_code_d = status_code_q;
							wp_d        = wp_enq;
							if (!await_q && !cmpl_q) begin
								pend_d = 1'b1;
							end
						end else begin
							cnt_poll_d = cnt_poll_q + 1'b1;
						end
						if (!pw_ready_q && pw_seen_q) begin
							if (cnt_ready_q > {1'b0, ready_delay_q}) begin
								pw_ready_d  = 1'b1;
								cnt_ready_d = '0;
							end else begin
								cnt_ready_d = cnt_ready_q + 1'b1;
							end
						end else begin
							cnt_ready_d = '0;
						end
						cnt_send_d = '0;
					end

					// silence watchdog: rebuild the queue with one poll
					if (cnt_sil_q > {1'b0, offline_ticks_q}) begin
						q_clr       = 1'b1;
						q_we        = 1'b1;
						q_waddr     = '0;
						last_code_d = status_code_q;
						wp_d        = FIRST_PTR;
						rp_d        = '0;
						offline_d   = 1'b1;
						await_d     = 1'b0;
						cmpl_d      = 1'b0;
						pend_d      = 1'b1;
						pw_on_d     = 1'b0;
						pw_seen_d   = 1'b0;
						pw_ready_d  = 1'b0;
						txpos_d     = '0;
						cnt_reply_d = '0;
						cnt_sil_d   = '0;
					end else begin
						cnt_sil_d = cnt_sil_q + 1'b1;
					end

					// finished reply: decode and move to the next command
					if (!await_d && cmpl_d) begin
						offline_d = 1'b0;
						cnt_sil_d = '0;
						if (rb_q[1] == STATUS_ID && last_code_d == status_code_q) begin
							if (rb_q[3][POWER_BIT]) begin
								pw_on_d = 1'b1;
								if (!pw_seen_q && rb_q[3] != POWER_ODD) begin
									pw_seen_d  = 1'b1;
									pw_ready_d = 1'b0;
								end
							end else begin
								pw_on_d    = 1'b0;
								pw_seen_d  = 1'b0;
								pw_ready_d = 1'b0;
							end
						end
						rp_d = rp_next;
						if (rp_next != wp_d) begin
							pend_d = 1'b1;
						end
						cmpl_d = 1'b0;
					end else if (await_d) begin
						// reply timeout: resend or drop
						if (cnt_reply_inc > {1'b0, reply_timeout_q}) begin
							cnt_reply_d = '0;
							if (try_inc >= max_tries_q) begin
								try_d = '0;
								if (rp_q == wp_d) begin
									await_d = 1'b0;
									cmpl_d  = 1'b0;
								end else begin
									rp_d = rp_next;
									if (rp_next != wp_d) begin
										pend_d  = 1'b1;
										await_d = 1'b0;
									end
								end
							end else begin
								try_d   = try_inc;
								pend_d  = 1'b1;
								await_d = 1'b0;
							end
						end else begin
							cnt_reply_d = cnt_reply_inc[TICK_W-1:0];
						end
					end
				end

				MODE_ENQUEUE: begin
					q_we        = 1'b1;
					q_wslot     = '{code: in_data.cmd_code, data: in_data.cmd_data,
						has_data: in_data.has_data};
					last_code_d = in_data.cmd_code;
					wp_d        = wp_enq;
					if (!await_q && !cmpl_q) begin
						pend_d = 1'b1;
					end
				end

				MODE_TX_REQ: begin
					if (txpos_q >= frame_len) begin
						// frame done: open the reply window
						for (int i = 0; i < REPLY_LENGTH; i++) begin
							rb_d[i] = '0;
						end
						await_d        = 1'b1;
						txpos_d        = '0;
						rxpos_d        = '0;
						cnt_reply_d    = '0;
						res.frame_sent = 1'b1;
					end else begin
						case (txpos_q)
							TXP_HDR:  res.tx_byte = HDR_BYTE;
							TXP_CODE: res.tx_byte = head.code;
							TXP_LEN:  res.tx_byte = head.has_data ? LEN_WITH_DATA : '0;
							TXP_DATA: res.tx_byte = head.has_data ? head.data : frame_sum;
							default:  res.tx_byte = frame_sum + head.data;
						endcase
						res.tx_valid = 1'b1;
						txpos_d      = txpos_q + 1'b1;
					end
				end

				MODE_RX_BYTE: begin
					// collect reply bytes, resync until the header shows up
					if (await_q) begin
						rb_d[rx_slot] = in_data.rx_byte;
						rxpos_d       = rx_slot;
						if (first_byte == REPLY_HDR) begin
							if (rx_inc >= RLEN) begin
								cmpl_d             = 1'b1;
								await_d            = 1'b0;
								rxpos_d            = '0;
								try_d              = '0;
								res.reply_received = 1'b1;
							end else begin
								rxpos_d = rx_inc[RXW-1:0];
							end
						end
					end
				end

				default: ;
			endcase
		end

		res.power_on    = pw_on_d;
		res.power_ready = pw_ready_d;
		res.offline     = offline_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_delay_q    <= RST_SEND_DELAY;
			poll_interval_q <= RST_POLL_INTERVAL;
			ready_delay_q   <= RST_READY_DELAY;
			reply_timeout_q <= RST_REPLY_TIMEOUT;
			offline_ticks_q <= RST_OFFLINE;
			max_tries_q     <= RST_MAX_TRIES;
			status_code_q   <= RST_STATUS_CODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SEND_DELAY:    send_delay_q    <= cfg_data;
				REG_POLL_INTERVAL: poll_interval_q <= cfg_data;
				REG_READY_DELAY:   ready_delay_q   <= cfg_data;
				REG_REPLY_TIMEOUT: reply_timeout_q <= cfg_data;
				REG_OFFLINE:       offline_ticks_q <= cfg_data;
				REG_MAX_TRIES:     max_tries_q     <= cfg_data[TRY_W-1:0];
				REG_STATUS_CODE:   status_code_q   <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// link state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= FIRST_PTR;
			rp_q        <= '0;
			last_code_q <= RST_STATUS_CODE;
			pend_q      <= 1'b1;
			await_q     <= 1'b0;
			cmpl_q      <= 1'b0;
			pw_on_q     <= 1'b0;
			pw_seen_q   <= 1'b0;
			pw_ready_q  <= 1'b0;
			offline_q   <= 1'b0;
			cnt_send_q  <= '0;
			cnt_poll_q  <= '0;
			cnt_ready_q <= '0;
			cnt_sil_q   <= '0;
			cnt_reply_q <= '0;
			try_q       <= '0;
			txpos_q     <= '0;
			rxpos_q     <= '0;
			for (int i = 0; i < REPLY_LENGTH; i++) begin
				rb_q[i] <= '0;
			end
		end else begin
			wp_q        <= wp_d;
			rp_q        <= rp_d;
			last_code_q <= last_code_d;
			pend_q      <= pend_d;
			await_q     <= await_d;
			cmpl_q      <= cmpl_d;
			pw_on_q     <= pw_on_d;
			pw_seen_q   <= pw_seen_d;
			pw_ready_q  <= pw_ready_d;
			offline_q   <= offline_d;
			cnt_send_q  <= cnt_send_d;
			cnt_poll_q  <= cnt_poll_d;
			cnt_ready_q <= cnt_ready_d;
			cnt_sil_q   <= cnt_sil_d;
			cnt_reply_q <= cnt_reply_d;
			try_q       <= try_d;
			txpos_q     <= txpos_d;
			rxpos_q     <= rxpos_d;
			rb_q        <= rb_d;
		end
	end

	// command ring with head prefetch at the next read slot
	sclr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (q_clr),
		.wr_en   (q_we),
		.wr_addr (q_waddr),
		.wr_slot (q_wslot),
		.rd_addr (rp_d),
		.head    (head)
	);

	// result buffer
	sclr_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_fire),
		.din        (res),
		.space      (space),
		.dout_valid (out_valid),
		.dout_ready (out_ready),
		.dout       (out_data)
	);

`ifndef SYNTH
	// a finished frame always opens the reply window
	a_frame_opens_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res.frame_sent) |=> await_q)
		else $error("reply wait not open after frame end");

	// a full reply closes the window and rewinds the capture position
	a_reply_closes_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res.reply_received) |=> (!await_q && cmpl_q && rxpos_q == '0))
		else $error("reply completion state wrong");

	// queueing a command never leaves the write slot on the read slot
	a_enqueue_keeps_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.mode == MODE_ENQUEUE) |=> (wp_q != rp_q))
		else $error("write pointer met read pointer after enqueue");

	// input back-pressure only with a result on show
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the serial command link with retry.
`timescale 1ns / 100ps

module testbench;
	import sclr_pkg::*;

	localparam int QDEPTH = DEF_QUEUE_DEPTH;
	localparam int RLEN   = DEF_REPLY_LENGTH;

	// Predicts the link's result beats and checks them in order.
	class link_scoreboard;
		logic [TICK_W-1:0] send_delay, poll_interval, ready_delay, reply_timeout;
		logic [TICK_W-1:0] offline_limit;
		logic [TRY_W-1:0]  max_tries;
		logic [BYTE_W-1:0] status_code;

		slot_t             cmd_ring[QDEPTH];
		int unsigned       wr_ptr, rd_ptr;
		logic [BYTE_W-1:0] last_code;
		bit                send_pending, awaiting, reply_done;
		bit                pw_on, pw_seen, pw_ready, is_offline;
		int unsigned       send_cnt, poll_cnt, ready_cnt, silence_cnt, reply_cnt;
		logic [TRY_W-1:0]  tries;
		int unsigned       tx_pos, rx_pos;
		logic [BYTE_W-1:0] reply_buf[RLEN];

		result_t link_results_due[$];
		int      failures;
		int      frames_seen, replies_seen, starts_seen, offline_seen;

		function new();
			failures = 0;
			frames_seen = 0;
			replies_seen = 0;
			starts_seen = 0;
			offline_seen = 0;
			send_delay = RST_SEND_DELAY;
			poll_interval = RST_POLL_INTERVAL;
			ready_delay = RST_READY_DELAY;
			reply_timeout = RST_REPLY_TIMEOUT;
			offline_limit = RST_OFFLINE;
			max_tries = RST_MAX_TRIES;
			status_code = RST_STATUS_CODE;
			last_code = '0;
			send_cnt = 0;
			poll_cnt = 0;
			ready_cnt = 0;
			silence_cnt = 0;
			reply_cnt = 0;
			tries = '0;
			rx_pos = 0;
			foreach (reply_buf[i]) reply_buf[i] = '0;
			init_link();
		endfunction

		function int unsigned ring_next(int unsigned p);
			return (p + 1 >= QDEPTH) ? 0 : p + 1;
		endfunction

		// Store a command; a full ring overwrites its newest slot.
		function void push_command(logic [7:0] code, logic [7:0] data, logic with_data);
			if (wr_ptr >= QDEPTH) wr_ptr = 0;
			cmd_ring[wr_ptr].code = code;
			cmd_ring[wr_ptr].data = data;
			cmd_ring[wr_ptr].has_data = with_data;
			last_code = code;
			wr_ptr = ring_next(wr_ptr);
			if (wr_ptr == rd_ptr) wr_ptr = (wr_ptr == 0) ? QDEPTH - 1 : wr_ptr - 1;
			if (!awaiting && !reply_done) send_pending = 1;
		endfunction

		// Rebuild the link with a single status poll queued.
		function void init_link();
			foreach (cmd_ring[i]) cmd_ring[i] = '0;
			is_offline = 0;
			awaiting = 0;
			reply_done = 0;
			send_pending = 0;
			pw_on = 0;
			pw_seen = 0;
			pw_ready = 0;
			tx_pos = 0;
			wr_ptr = 0;
			rd_ptr = 0;
			reply_cnt = 0;
			push_command(status_code, '0, 1'b0);
		endfunction

		// Update power flags from a status reply.
		function void decode_status();
			if (reply_buf[1] != STATUS_ID || last_code != status_code) return;
			if (reply_buf[3][POWER_BIT]) begin
				pw_on = 1;
				if (!pw_seen && reply_buf[3] != POWER_ODD) begin
					pw_seen = 1;
					pw_ready = 0;
				end
			end else begin
				pw_on = 0;
				pw_seen = 0;
				pw_ready = 0;
			end
		endfunction

		// Advance every tick counter; return whether a send starts.
		function bit run_tick();
			bit started;
			started = 0;
			if (send_pending) begin
				if (send_cnt > send_delay) begin
					send_pending = 0;
					rx_pos = 0;
					send_cnt = 0;
					started = 1;
				end else begin
					send_cnt++;
				end
				poll_cnt = 0;
			end else begin
				if (poll_cnt > poll_interval) begin
					poll_cnt = 0;
					push_command(status_code, '0, 1'b0);
				end else begin
					poll_cnt++;
				end
				if (!pw_ready && pw_seen) begin
					if (ready_cnt > ready_delay) begin
						pw_ready = 1;
						ready_cnt = 0;
					end else begin
						ready_cnt++;
					end
				end else begin
					ready_cnt = 0;
				end
				send_cnt = 0;
			end

			// reset the link after long silence
			if (silence_cnt > offline_limit) begin
				init_link();
				is_offline = 1;
				silence_cnt = 0;
			end else begin
				silence_cnt++;
			end

			// consume a finished reply, or count toward a retry
			if (!awaiting && reply_done) begin
				is_offline = 0;
				silence_cnt = 0;
				decode_status();
				rd_ptr = ring_next(rd_ptr);
				if (rd_ptr != wr_ptr) send_pending = 1;
				reply_done = 0;
			end else if (awaiting) begin
				reply_cnt++;
				if (reply_cnt > reply_timeout) begin
					reply_cnt = 0;
					tries = tries + 1'b1;
					if (tries >= max_tries) begin
						tries = '0;
						if (rd_ptr == wr_ptr) begin
							awaiting = 0;
							reply_done = 0;
						end else begin
							rd_ptr = ring_next(rd_ptr);
							if (rd_ptr != wr_ptr) begin
								send_pending = 1;
								awaiting = 0;
							end
						end
					end else begin
						send_pending = 1;
						awaiting = 0;
					end
				end
			end
			return started;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SEND_DELAY:    send_delay = val;
				REG_POLL_INTERVAL: poll_interval = val;
				REG_READY_DELAY:   ready_delay = val;
				REG_REPLY_TIMEOUT: reply_timeout = val;
				REG_OFFLINE:       offline_limit = val;
				REG_MAX_TRIES:     max_tries = val[TRY_W-1:0];
				REG_STATUS_CODE:   status_code = val[BYTE_W-1:0];
				default: ;
			endcase
		endfunction

		// Work out the result of one accepted input beat and hold it.
		function void note_input(in_item_t it);
			result_t     r;
			slot_t       head;
			int unsigned flen;
			logic [7:0]  len, sum;
			r = '0;
			case (it.mode)
				MODE_TICK: r.start_send = run_tick();
				MODE_ENQUEUE: push_command(it.cmd_code, it.cmd_data, it.has_data);
				MODE_TX_REQ: begin
					head = cmd_ring[rd_ptr < QDEPTH ? rd_ptr : 0];
					flen = head.has_data ? FRAME_LEN_DATA : FRAME_LEN_BARE;
					if (tx_pos >= flen) begin
						foreach (reply_buf[i]) reply_buf[i] = '0;
						awaiting = 1;
						tx_pos = 0;
						rx_pos = 0;
						reply_cnt = 0;
						r.frame_sent = 1;
					end else begin
						len = head.has_data ? LEN_WITH_DATA : 8'h00;
						sum = HDR_BYTE + head.code + len;
						case (tx_pos)
							TXP_HDR:  r.tx_byte = HDR_BYTE;
							TXP_CODE: r.tx_byte = head.code;
							TXP_LEN:  r.tx_byte = len;
							TXP_DATA: r.tx_byte = head.has_data ? head.data : sum;
							default:  r.tx_byte = sum + head.data;
						endcase
						r.tx_valid = 1;
						tx_pos++;
					end
				end
				default: begin
					if (awaiting) begin
						if (rx_pos >= RLEN) rx_pos = 0;
						reply_buf[rx_pos] = it.rx_byte;
						if (reply_buf[0] == REPLY_HDR) begin
							rx_pos++;
							if (rx_pos >= RLEN) begin
								reply_done = 1;
								awaiting = 0;
								rx_pos = 0;
								tries = '0;
								r.reply_received = 1;
							end
						end
					end
				end
			endcase
			r.power_on = pw_on;
			r.power_ready = pw_ready;
			r.offline = is_offline;
			link_results_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				failures++;
			end
		endfunction

		// Compare one result beat with the oldest prediction.
		function void check_result(result_t got);
			result_t want;
			if (link_results_due.size() == 0) begin
				$error("result beat with no prediction waiting: %h", got);
				failures++;
				return;
			end
			want = link_results_due.pop_front();
			compare_field("tx_byte", want.tx_byte, got.tx_byte);
			compare_field("tx_valid", want.tx_valid, got.tx_valid);
			compare_field("frame_sent", want.frame_sent, got.frame_sent);
			compare_field("start_send", want.start_send, got.start_send);
			compare_field("reply_received", want.reply_received, got.reply_received);
			compare_field("power_on", want.power_on, got.power_on);
			compare_field("power_ready", want.power_ready, got.power_ready);
			compare_field("offline", want.offline, got.offline);
			frames_seen += want.frame_sent;
			replies_seen += want.reply_received;
			starts_seen += want.start_send;
			offline_seen += want.offline;
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	in_item_t in_data;
	logic     out_valid;
	logic     out_ready = 1'b0;
	result_t  out_data;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	link_scoreboard sb = new();

	int items_sent = 0;
	int settings_used = 0;
	int burst_left = 0;
	bit quiet_sender = 0;
	int stall_style = 0;
	int stall_left = 0;
	int unsigned rx_cycle = 0;

	// shadow of the settings, used to shape the stimulus
	int cur_send_delay = RST_SEND_DELAY;
	logic [7:0] cur_status_code = RST_STATUS_CODE;

	serial_command_link_with_retry #(
		.QUEUE_DEPTH (QDEPTH),
		.REPLY_LENGTH(RLEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: switch among always-ready, random and periodic stalls.
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 2);
			stall_left <= $urandom_range(32, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ((rx_cycle % 7) < 4);
		endcase
	end

	// Check each result beat as it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Drive one input beat; the sender runs in bursts, with gaps between them unless quiet_sender is set.
	task automatic send_beat(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 5) == 0) quiet_sender = !quiet_sender;
			gap = quiet_sender ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// Drain the link, then load a full register set.
	task automatic program_link(int sd, int pi, int rd, int rt, int ol, int mt, int sc);
		@(negedge clk) in_valid <= 1'b0;
		burst_left = 0;
		while (sb.link_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_SEND_DELAY, CFG_DATA_W'(sd));
		write_reg(REG_POLL_INTERVAL, CFG_DATA_W'(pi));
		write_reg(REG_READY_DELAY, CFG_DATA_W'(rd));
		write_reg(REG_REPLY_TIMEOUT, CFG_DATA_W'(rt));
		write_reg(REG_OFFLINE, CFG_DATA_W'(ol));
		write_reg(REG_MAX_TRIES, CFG_DATA_W'(mt));
		write_reg(REG_STATUS_CODE, CFG_DATA_W'(sc));
		@(negedge clk) cfg_valid <= 1'b0;
		cur_send_delay = sd;
		cur_status_code = 8'(sc);
		settings_used++;
	endtask

	// Random beat with every field filled.
	function automatic in_item_t rand_item();
		logic [31:0] r;
		r = $urandom;
		return r[$bits(in_item_t)-1:0];
	endfunction

	// Item builders; fields the mode ignores carry random values.
	function automatic in_item_t tick_item();
		in_item_t it;
		it = rand_item();
		it.mode = MODE_TICK;
		return it;
	endfunction

	function automatic in_item_t queue_item(logic [7:0] code, logic [7:0] data, logic hd);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_ENQUEUE;
		it.cmd_code = code;
		it.cmd_data = data;
		it.has_data = hd;
		return it;
	endfunction

	function automatic in_item_t tx_item();
		in_item_t it;
		it = rand_item();
		it.mode = MODE_TX_REQ;
		return it;
	endfunction

	function automatic in_item_t rx_item(logic [7:0] b);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_RX_BYTE;
		it.rx_byte = b;
		return it;
	endfunction

	function automatic logic [7:0] pick_code();
		return ($urandom_range(0, 1) == 0) ? cur_status_code : 8'($urandom);
	endfunction

	// Full exchange: queue, send ticks toward the send delay, pull the frame, answer it.
	task automatic play_exchange();
		int n;
		logic [7:0] pw;
		n = $urandom_range(0, 2);
		repeat (n) send_beat(queue_item(pick_code(), 8'($urandom), 1'($urandom)));
		n = $urandom_range(1, (cur_send_delay < 8 ? cur_send_delay : 8) + 3);
		repeat (n) send_beat(tick_item());
		n = $urandom_range(4, 6);
		repeat (n) send_beat(tx_item());
		if ($urandom_range(0, 5) == 0) send_beat(rx_item(8'($urandom)));
		case ($urandom_range(0, 4))
			0:       pw = 8'h80;
			1:       pw = POWER_ODD;
			2:       pw = 8'h00;
			3:       pw = 8'hFF;
			default: pw = 8'($urandom);
		endcase
		send_beat(rx_item(REPLY_HDR));
		send_beat(rx_item(($urandom_range(0, 3) != 0) ? STATUS_ID : 8'($urandom)));
		send_beat(rx_item(8'($urandom)));
		send_beat(rx_item(pw));
		send_beat(rx_item(8'($urandom)));
		n = $urandom_range(1, 3);
		repeat (n) send_beat(tick_item());
	endtask

	// Broken traffic: cut-off replies or long runs of ticks with no answer.
	task automatic play_broken();
		int n;
		if ($urandom_range(0, 1) == 0) begin
			n = $urandom_range(4, 6);
			repeat (n) send_beat(tx_item());
			send_beat(rx_item(REPLY_HDR));
			n = $urandom_range(0, 3);
			repeat (n) send_beat(rx_item(8'($urandom)));
		end
		n = $urandom_range(1, 15);
		repeat (n) send_beat(tick_item());
	endtask

	task automatic run_random(int count);
		int stop_at;
		int n;
		in_item_t it;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			n = $urandom_range(0, 99);
			if (n < 60) begin
				play_exchange();
			end else if (n < 72) begin
				// overfill the ring
				n = $urandom_range(6, 10);
				repeat (n) send_beat(queue_item(pick_code(), 8'($urandom), 1'($urandom)));
			end else if (n < 86) begin
				play_broken();
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					it = rand_item();
					send_beat(it);
				end
			end
		end
	endtask

	// Hard stop for a hung run.
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: short delays, then one frame and reply by hand
		program_link(1, 3, 2, 4, 40, 2, 0);
		send_beat(rx_item(8'hFF));                   // byte outside a reply wait
		send_beat(tx_item());                        // request before any start
		send_beat(queue_item(8'h00, 8'hFF, 1'b1));
		repeat (3) send_beat(tick_item());
		repeat (4) send_beat(tx_item());             // finish the frame, then end it
		send_beat(rx_item(8'h55));                   // bad header gets overwritten
		send_beat(rx_item(REPLY_HDR));
		send_beat(rx_item(STATUS_ID));
		send_beat(rx_item(8'h00));
		send_beat(rx_item(8'h80));
		send_beat(rx_item(8'hFF));
		repeat (3) send_beat(tick_item());
		send_beat(queue_item(8'hFF, 8'h00, 1'b0));
		repeat (2) send_beat(tx_item());

		// extremes of every register
		program_link(0, 0, 0, 0, 0, 1, 0);
		run_random(60);
		program_link(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15, 8'hFF);
		run_random(60);

		// random settings with short delays so frames and replies keep flowing
		repeat (7) begin
			program_link($urandom_range(0, 4), $urandom_range(0, 15),
				$urandom_range(0, 10), $urandom_range(0, 12),
				$urandom_range(10, 150), $urandom_range(1, 6), $urandom_range(0, 255));
			run_random(200);
		end

		// drain and settle
		@(negedge clk) in_valid <= 1'b0;
		guard = 0;
		while (sb.link_results_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (5) @(posedge clk);
		if (sb.link_results_due.size() != 0) begin
			$error("%0d predicted results never arrived", sb.link_results_due.size());
			sb.failures++;
		end

		$display("Ran %0d events over %0d register settings.", items_sent, settings_used);
		$display("Saw %0d send starts, %0d frames, %0d replies, %0d offline beats.",
			sb.starts_seen, sb.frames_seen, sb.replies_seen, sb.offline_seen);
		if (sb.failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
